// ----- sv/mtg_pkg.sv -----
`timescale 1ns / 1ps
// mtg_pkg: shared types, constants and word functions of the mt19937 generator
// depends on nothing; imported by every other file of the block but mtg_ram

package mtg_pkg;

  localparam int WORD_W          = 32;
  localparam int STATE_DEPTH_DEF = 624;
  localparam int TWIST_OFFSET    = 397;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_B0DF;
  localparam logic [WORD_W-1:0] UPPER_MASK   = 32'h8000_0000;
  localparam logic [WORD_W-1:0] LOWER_MASK   = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9D2C_5680;
  localparam logic [WORD_W-1:0] TEMPER_C     = 32'hEFC6_0000;

  localparam int MULT_W = 17;
  localparam logic [MULT_W-1:0] SEED_MULT = 17'd69069;

  localparam int TEMPER_U = 11;
  localparam int TEMPER_S = 7;
  localparam int TEMPER_T = 15;
  localparam int TEMPER_L = 18;

  typedef enum logic {
    OP_GENERATE = 1'b0,
    OP_SEED     = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_RD_CUR,
    ST_RD_NXT,
    ST_RD_FAR,
    ST_WRITE_BACK,
    ST_UNSEEDED
  } back_state_e;

  // classified request handed from front to back
  typedef struct packed {
    opcode_e           opcode;
    logic [WORD_W-1:0] seed_value;
  } cmd_t;

  // result payload
  typedef struct packed {
    logic [WORD_W-1:0] number;
    logic              valid_res;
  } res_t;

  // one step of the mt19937 recurrence
  function automatic logic [WORD_W-1:0] twist_word(input logic [WORD_W-1:0] cur,
                                                   input logic [WORD_W-1:0] nxt,
                                                   input logic [WORD_W-1:0] far);
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] v;
    y = (cur & UPPER_MASK) | (nxt & LOWER_MASK);
    v = far ^ (y >> 1);
    if (y[0]) begin
      v = v ^ TWIST_MATRIX;
    end
    return v;
  endfunction

  // output tempering
  function automatic logic [WORD_W-1:0] temper_word(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] x;
    x = w;
    x = x ^ (x >> TEMPER_U);
    x = x ^ ((x << TEMPER_S) & TEMPER_B);
    x = x ^ ((x << TEMPER_T) & TEMPER_C);
    x = x ^ (x >> TEMPER_L);
    return x;
  endfunction

endpackage

// ----- sv/mtg_if.sv -----
`timescale 1ns / 1ps
// mtg_req_if and mtg_res_if: valid/ready channels of the mt19937 generator
// depends on mtg_pkg for the word width

interface mtg_req_if import mtg_pkg::*;;
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [WORD_W-1:0] seed_value;

  modport source (output valid, output opcode, output seed_value, input ready);
  modport sink   (input valid, input opcode, input seed_value, output ready);
endinterface

interface mtg_res_if import mtg_pkg::*;;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] number;
  logic              valid_res;

  modport source (output valid, output number, output valid_res, input ready);
  modport sink   (input valid, input number, input valid_res, output ready);
endinterface

// ----- sv/mersenne_twister_generator_core.sv -----
`timescale 1ns / 1ps
// generate: the back end reads the current, next and far words in turn through the
//   single read port of the state ram, then writes back and loads the result register,
//   stalling while the result slot is full; it takes a new request only once idle again
// seed: one state word written per cycle over the whole state ram, no result
// generate before any seed: result with valid_res 0 and number 0
// reset (rst_ni low, async): queue empty, generator unseeded; the state ram is not cleared

module mersenne_twister_generator_core import mtg_pkg::*; #(
  parameter int STATE_DEPTH = STATE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mtg_req_if.sink    req_i,
  mtg_res_if.source  res_o
);

  // front to back request queue handshake
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  // front end: takes requests while the back end is busy, up to the queue depth,
  // and decodes the opcode
  mtg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // back end: seeds the state ram with the 69069 recurrence, or twists the word at the read
  // index on demand (same result as a bulk twist, since words below the index are already
  // new) and tempers it into the result register, which gets a zero result before any seed
  mtg_back #(
    .STATE_DEPTH(STATE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .res_o       (res_o)
  );

endmodule

// ----- sv/mtg_ram.sv -----
`timescale 1ns / 1ps
// mtg_ram: generic single write, single read ram with registered read data
// depends on nothing

module mtg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/mtg_front.sv -----
`timescale 1ns / 1ps
// mtg_front: accepts requests, classifies them and queues them for the back end
// depends on mtg_pkg and mtg_req_if

module mtg_front import mtg_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  mtg_req_if.sink       req_i,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output cmd_t          cmd_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = PTR_W + 1;

  cmd_t             queue_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;
  cmd_t             cmd_in;

  // classify the raw request
  always_comb begin
    cmd_in.opcode     = (req_i.opcode == OP_SEED) ? OP_SEED : OP_GENERATE;
    cmd_in.seed_value = req_i.seed_value;
  end

  assign req_i.ready = (count_q != CNT_W'(QUEUE_DEPTH));
  assign push        = req_i.valid && req_i.ready;
  assign cmd_valid_o = (count_q != '0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// ----- sv/mtg_back.sv -----
`timescale 1ns / 1ps
// mtg_back: seeding and on-demand twisting sequencer over the state ram
// depends on mtg_pkg, mtg_res_if and mtg_ram

module mtg_back import mtg_pkg::*; #(
  parameter int STATE_DEPTH = STATE_DEPTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cmd_valid_i,
  output logic     cmd_ready_o,
  input  cmd_t     cmd_i,
  mtg_res_if.source res_o
);

  localparam int IDX_W = $clog2(STATE_DEPTH);

  back_state_e state_q, state_d;

  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [IDX_W-1:0]  cnt_q, cnt_d;
  logic              seeded_q, seeded_d;
  logic [WORD_W-1:0] seed_word_q;
  logic [WORD_W-1:0] cur_q, nxt_q;

  logic [IDX_W-1:0]  idx_nxt;
  logic [IDX_W:0]    far_sum;
  logic [IDX_W-1:0]  idx_far;

  logic [WORD_W+MULT_W-1:0] seed_prod;
  logic [WORD_W-1:0]        new_word;

  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  logic res_valid_q;
  res_t res_q, res_d;
  logic slot_free, load_res;

  // neighbor addresses with wrap
  assign idx_nxt = (idx_q == IDX_W'(STATE_DEPTH - 1)) ? '0 : idx_q + IDX_W'(1);
  assign far_sum = {1'b0, idx_q} + (IDX_W+1)'(TWIST_OFFSET);
  assign idx_far = (far_sum >= (IDX_W+1)'(STATE_DEPTH))
                 ? IDX_W'(far_sum - (IDX_W+1)'(STATE_DEPTH))
                 : far_sum[IDX_W-1:0];

  assign seed_prod = seed_word_q * SEED_MULT;
  assign new_word  = twist_word(cur_q, nxt_q, ram_rdata);
  assign slot_free = !res_valid_q || res_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.opcode == OP_SEED) begin
            state_d = ST_SEED;
          end else if (seeded_q) begin
            state_d = ST_RD_CUR;
          end else begin
            state_d = ST_UNSEEDED;
          end
        end
      end
      ST_SEED: begin
        if (cnt_q == IDX_W'(STATE_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_RD_CUR:     state_d = ST_RD_NXT;
      ST_RD_NXT:     state_d = ST_RD_FAR;
      ST_RD_FAR:     state_d = ST_WRITE_BACK;
      ST_WRITE_BACK: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_UNSEEDED: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_ready_o = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = idx_q;
    ram_wdata   = new_word;
    ram_re      = 1'b0;
    ram_raddr   = idx_q;
    load_res    = 1'b0;
    res_d       = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
      end
      ST_SEED: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = seed_word_q;
      end
      ST_RD_CUR: begin
        ram_re    = 1'b1;
        ram_raddr = idx_q;
      end
      ST_RD_NXT: begin
        ram_re    = 1'b1;
        ram_raddr = idx_nxt;
      end
      ST_RD_FAR: begin
        ram_re    = 1'b1;
        ram_raddr = idx_far;
      end
      ST_WRITE_BACK: begin
        if (slot_free) begin
          ram_we          = 1'b1;
          load_res        = 1'b1;
          res_d.number    = temper_word(new_word);
          res_d.valid_res = 1'b1;
        end
      end
      ST_UNSEEDED: begin
        load_res = slot_free;
      end
      default: begin
        cmd_ready_o = 1'b0;
      end
    endcase
  end

  // control counters
  always_comb begin
    idx_d    = idx_q;
    cnt_d    = cnt_q;
    seeded_d = seeded_q;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
      end
      ST_SEED: begin
        cnt_d = cnt_q + IDX_W'(1);
        if (cnt_q == IDX_W'(STATE_DEPTH - 1)) begin
          idx_d    = '0;
          seeded_d = 1'b1;
        end
      end
      ST_WRITE_BACK: begin
        if (slot_free) begin
          idx_d = idx_nxt;
        end
      end
      default: begin
        idx_d = idx_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      cnt_q       <= '0;
      seeded_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      cnt_q    <= cnt_d;
      seeded_q <= seeded_d;
      if (load_res) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && cmd_valid_i && cmd_i.opcode == OP_SEED) begin
      seed_word_q <= cmd_i.seed_value;
    end else if (state_q == ST_SEED) begin
      seed_word_q <= seed_prod[WORD_W-1:0];
    end
    if (state_q == ST_RD_NXT) begin
      cur_q <= ram_rdata;
    end
    if (state_q == ST_RD_FAR) begin
      nxt_q <= ram_rdata;
    end
    if (load_res) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid     = res_valid_q;
  assign res_o.number    = res_q.number;
  assign res_o.valid_res = res_q.valid_res;

  mtg_ram #(
    .WIDTH(WORD_W),
    .DEPTH(STATE_DEPTH)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

// ----- sv/mtg_checker.sv -----
`timescale 1ns / 1ps
// mtg_checker: port level checks of the mt19937 generator core, bound to the top level
// depends on mtg_pkg and mersenne_twister_generator_core

module mtg_checker import mtg_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_valid_i,
  input logic              req_ready_i,
  input logic              req_opcode_i,
  input logic              res_valid_i,
  input logic              res_ready_i,
  input logic [WORD_W-1:0] res_number_i,
  input logic              res_valid_res_i
);

  logic       seen_seed_q;
  logic [3:0] pending_q;
  logic       gen_acc, res_acc;

  assign gen_acc = req_valid_i && req_ready_i && (req_opcode_i == OP_GENERATE);
  assign res_acc = res_valid_i && res_ready_i;

  // track seeds seen and generate requests still owed a result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_seed_q <= 1'b0;
      pending_q   <= '0;
    end else begin
      if (req_valid_i && req_ready_i && req_opcode_i == OP_SEED) begin
        seen_seed_q <= 1'b1;
      end
      if (gen_acc && !res_acc) begin
        pending_q <= pending_q + 4'd1;
      end else if (res_acc && !gen_acc) begin
        pending_q <= pending_q - 4'd1;
      end
    end
  end

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result valid dropped while stalled");

  a_res_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(res_number_i) && $stable(res_valid_res_i))
    else $error("result changed while stalled");

  a_unseeded_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_valid_res_i |-> res_number_i == '0)
    else $error("unseeded result carries a nonzero number");

  a_seed_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_valid_res_i |-> seen_seed_q)
    else $error("seeded result before any seed request");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> pending_q != 4'd0)
    else $error("result without an outstanding generate request");

endmodule

bind mersenne_twister_generator_core mtg_checker u_mtg_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .req_opcode_i    (req_i.opcode),
  .res_valid_i     (res_o.valid),
  .res_ready_i     (res_o.ready),
  .res_number_i    (res_o.number),
  .res_valid_res_i (res_o.valid_res)
);
